>>> hw/rtl/fsk2a_pkg.sv
// Shared types, constants and register codes for the FSK2a pulse modulator.
package fsk2a_pkg;

    localparam int TICKS_PER_CYCLE_DEF = 8;
    localparam int MAX_ENTRIES_DEF     = 4096;
    localparam int MAX_FRAME_BITS_DEF  = 256;

    localparam int TOP_W      = 16;
    localparam int TONE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int OUT_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_TOP    = 3;

    localparam logic [TOP_W-1:0]  TOP_RST       = 16'd8;
    localparam logic [TONE_W-1:0] SHORT_CYC_RST = 8'd8;
    localparam logic [TONE_W-1:0] LONG_CYC_RST  = 8'd10;
    localparam logic [TONE_W-1:0] MARK_CYC_RST  = 8'd5;
    localparam logic [CNT_W-1:0]  SHORT_CNT_RST = 6'd6;
    localparam logic [CNT_W-1:0]  LONG_CNT_RST  = 6'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP       = 3'd0,
        CFG_SHORT_CYC = 3'd1,
        CFG_LONG_CYC  = 3'd2,
        CFG_MARK_CYC  = 3'd3,
        CFG_SHORT_CNT = 3'd4,
        CFG_LONG_CNT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TIMING = 2'd1,
        ST_LONG   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DIV_SHORT = 2'd0,
        DIV_LONG  = 2'd1,
        DIV_MARK  = 2'd2
    } t_div_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TOP_W-1:0]  top;
        logic [TONE_W-1:0] short_cyc;
        logic [TONE_W-1:0] long_cyc;
        logic [TONE_W-1:0] mark_cyc;
        logic [CNT_W-1:0]  short_cnt;
        logic [CNT_W-1:0]  long_cnt;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage

>>> hw/rtl/fsk2a_cfg.sv
// Configuration register file for the FSK2a pulse modulator.
module fsk2a_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsk2a_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fsk2a_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output fsk2a_pkg::t_cfg                    o_cfg
);

    fsk2a_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top       <= fsk2a_pkg::TOP_RST;
            r_cfg.short_cyc <= fsk2a_pkg::SHORT_CYC_RST;
            r_cfg.long_cyc  <= fsk2a_pkg::LONG_CYC_RST;
            r_cfg.mark_cyc  <= fsk2a_pkg::MARK_CYC_RST;
            r_cfg.short_cnt <= fsk2a_pkg::SHORT_CNT_RST;
            r_cfg.long_cnt  <= fsk2a_pkg::LONG_CNT_RST;
        end else if (i_cfg_we) begin
            unique case (fsk2a_pkg::t_cfg_idx'(i_cfg_idx))
                fsk2a_pkg::CFG_TOP: begin
                    r_cfg.top <= i_cfg_wdata[fsk2a_pkg::TOP_W-1:0];
                end
                fsk2a_pkg::CFG_SHORT_CYC: begin
                    r_cfg.short_cyc <= i_cfg_wdata[fsk2a_pkg::TONE_W-1:0];
                end
                fsk2a_pkg::CFG_LONG_CYC: begin
                    r_cfg.long_cyc <= i_cfg_wdata[fsk2a_pkg::TONE_W-1:0];
                end
                fsk2a_pkg::CFG_MARK_CYC: begin
                    r_cfg.mark_cyc <= i_cfg_wdata[fsk2a_pkg::TONE_W-1:0];
                end
                fsk2a_pkg::CFG_SHORT_CNT: begin
                    r_cfg.short_cnt <= i_cfg_wdata[fsk2a_pkg::CNT_W-1:0];
                end
                fsk2a_pkg::CFG_LONG_CNT: begin
                    r_cfg.long_cnt <= i_cfg_wdata[fsk2a_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/fsk2a_div.sv
// Shared restoring divider, one quotient bit per cycle.
module fsk2a_div #(
    parameter int DW = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DW-1:0]                  i_dividend,
    input  logic [fsk2a_pkg::TOP_W-1:0]    i_divisor,
    output fsk2a_pkg::t_div_stat           o_stat,
    output logic [DW-1:0]                  o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [DW-1:0]                 r_quot;
    logic [fsk2a_pkg::TOP_W-1:0]   r_rem;
    logic [fsk2a_pkg::TOP_W-1:0]   r_divisor;
    logic [fsk2a_pkg::TOP_W:0]     w_rem_sh;
    logic                          w_ge;

    assign w_rem_sh = {r_rem, r_quot[DW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Dividend bits shift out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-2:0], w_ge};
            if (w_ge) begin
                r_rem <= fsk2a_pkg::TOP_W'(w_rem_sh - {1'b0, r_divisor});
            end else begin
                r_rem <= w_rem_sh[fsk2a_pkg::TOP_W-1:0];
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_quot          = r_quot;

endmodule

>>> hw/rtl/fsk2a_pulse_modulator.sv
// Top level of the FSK2a pulse modulator: sequencer, frame counters and result register.
//
// Each frame bit is taken on the input channel and turned into one result per tone
// pulse (or a single error result). The divisions by counter_top_ticks (short
// tone, long tone, mark) run one after another through one restoring divider of W
// bits, W = clog2(255 * TICKS_PER_CYCLE + 1) (11 at the default), and stop at the
// first one that leaves a remainder. For each division the sequencer passes through
// S_DIV_GO and S_DIV_WAIT; after the mark it passes S_MUL and S_CHECK, and S_EMIT
// then offers the results, one result per cycle while the output side takes them.
// A counter top below the minimum is reported in the cycle after the bit is taken;
// a remainder error is offered once the division of the short tone, the long tone
// or the mark that left it is done. The input is not ready until the last result
// of the previous bit has been taken; configuration must only be written while the
// block is idle.
module fsk2a_pulse_modulator #(
    parameter int TICKS_PER_CYCLE = fsk2a_pkg::TICKS_PER_CYCLE_DEF,
    parameter int MAX_ENTRIES     = fsk2a_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_FRAME_BITS  = fsk2a_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsk2a_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fsk2a_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_data_bit,
    input  logic                               i_last_bit,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fsk2a_pkg::OUT_W-1:0]        o_high_entries,
    output logic [fsk2a_pkg::OUT_W-1:0]        o_low_entries,
    output logic                               o_tone_is_long,
    output logic                               o_last_of_bit,
    output logic [1:0]                         o_status
);

    localparam int DW    = $clog2((2 ** fsk2a_pkg::TONE_W - 1) * TICKS_PER_CYCLE + 1);
    localparam int TOT_W = DW + fsk2a_pkg::CNT_W;
    localparam int EW    = $clog2(MAX_ENTRIES + 1);
    localparam int BW    = $clog2(MAX_FRAME_BITS + 1);
    localparam int SUM_W = ((EW > TOT_W) ? EW : TOT_W) + 1;

    fsk2a_pkg::t_cfg       w_cfg;
    fsk2a_pkg::t_div_stat  w_div_stat;
    fsk2a_pkg::t_state     r_state, n_state;
    fsk2a_pkg::t_div_sel   r_sel;
    fsk2a_pkg::t_status    r_status;

    logic                          w_div_start;
    logic [DW-1:0]                 w_dividend;
    logic [DW-1:0]                 w_quot;
    logic [fsk2a_pkg::TONE_W-1:0]  w_tone;
    logic [fsk2a_pkg::CNT_W-1:0]   w_pulses;
    logic [DW-1:0]                 w_hi;
    logic                          w_too_long;
    logic                          w_empty;
    logic                          w_accept;
    logic                          w_out_take;
    logic                          w_final;

    logic                          r_bit;
    logic                          r_last;
    logic [DW-1:0]                 r_tone_ent;
    logic [DW-1:0]                 r_mark_e;
    logic [TOT_W-1:0]              r_total;
    logic [fsk2a_pkg::CNT_W-1:0]   r_left;
    logic [fsk2a_pkg::OUT_W-1:0]   r_hi;
    logic [fsk2a_pkg::OUT_W-1:0]   r_lo;
    logic [EW-1:0]                 r_entries;
    logic [BW-1:0]                 r_bits;

    fsk2a_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    always_comb begin
        case (r_sel)
            fsk2a_pkg::DIV_SHORT: w_tone = w_cfg.short_cyc;
            fsk2a_pkg::DIV_LONG:  w_tone = w_cfg.long_cyc;
            default:              w_tone = w_cfg.mark_cyc;
        endcase
    end

    assign w_dividend = DW'(32'(w_tone) * TICKS_PER_CYCLE);

    fsk2a_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_cfg.top),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    assign w_pulses   = r_bit ? w_cfg.long_cnt : w_cfg.short_cnt;
    assign w_hi       = (r_mark_e < r_tone_ent) ? r_mark_e : r_tone_ent;
    assign w_too_long = ((BW + 1)'(r_bits) + 1'b1 > (BW + 1)'(MAX_FRAME_BITS))
                     || (SUM_W'(r_entries) + SUM_W'(r_total) > SUM_W'(MAX_ENTRIES));
    assign w_empty    = (r_tone_ent == '0) || (w_pulses == '0);

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = o_out_valid && i_out_ready;
    assign w_final    = (r_status != fsk2a_pkg::ST_OK)
                     || (r_left == fsk2a_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsk2a_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            fsk2a_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (w_cfg.top < fsk2a_pkg::TOP_W'(fsk2a_pkg::MIN_TOP)) begin
                        n_state = fsk2a_pkg::S_EMIT;
                    end else begin
                        n_state = fsk2a_pkg::S_DIV_GO;
                    end
                end
            end
            fsk2a_pkg::S_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = fsk2a_pkg::S_DIV_WAIT;
            end
            fsk2a_pkg::S_DIV_WAIT: begin
                if (w_div_stat.done) begin
                    if (!w_div_stat.rem_zero) begin
                        n_state = fsk2a_pkg::S_EMIT;
                    end else if (r_sel == fsk2a_pkg::DIV_MARK) begin
                        n_state = fsk2a_pkg::S_MUL;
                    end else begin
                        n_state = fsk2a_pkg::S_DIV_GO;
                    end
                end
            end
            fsk2a_pkg::S_MUL: begin
                n_state = fsk2a_pkg::S_CHECK;
            end
            fsk2a_pkg::S_CHECK: begin
                if (!w_too_long && w_empty) begin
                    n_state = fsk2a_pkg::S_IDLE;
                end else begin
                    n_state = fsk2a_pkg::S_EMIT;
                end
            end
            fsk2a_pkg::S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready && w_final) begin
                    n_state = fsk2a_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsk2a_pkg::S_IDLE;
            end
        endcase
    end

    // Frame counters; drop them after the last bit of a frame, error or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_bits    <= '0;
        end else if (r_state == fsk2a_pkg::S_CHECK && !w_too_long) begin
            if (w_empty && r_last) begin
                r_entries <= '0;
                r_bits    <= '0;
            end else begin
                r_entries <= EW'(SUM_W'(r_entries) + SUM_W'(r_total));
                r_bits    <= r_bits + 1'b1;
            end
        end else if (w_out_take && w_final && r_last) begin
            r_entries <= '0;
            r_bits    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bit  <= i_data_bit;
            r_last <= i_last_bit;
            r_sel  <= fsk2a_pkg::DIV_SHORT;
            r_hi   <= '0;
            r_lo   <= '0;
            if (w_cfg.top < fsk2a_pkg::TOP_W'(fsk2a_pkg::MIN_TOP)) begin
                r_status <= fsk2a_pkg::ST_TIMING;
            end else begin
                r_status <= fsk2a_pkg::ST_OK;
            end
        end
        if (r_state == fsk2a_pkg::S_DIV_WAIT && w_div_stat.done) begin
            if (!w_div_stat.rem_zero) begin
                r_status <= fsk2a_pkg::ST_TIMING;
            end
            case (r_sel)
                fsk2a_pkg::DIV_SHORT: begin
                    if (!r_bit) begin
                        r_tone_ent <= w_quot;
                    end
                    r_sel <= fsk2a_pkg::DIV_LONG;
                end
                fsk2a_pkg::DIV_LONG: begin
                    if (r_bit) begin
                        r_tone_ent <= w_quot;
                    end
                    r_sel <= fsk2a_pkg::DIV_MARK;
                end
                default: begin
                    r_mark_e <= w_quot;
                end
            endcase
        end
        if (r_state == fsk2a_pkg::S_MUL) begin
            r_total <= TOT_W'(r_tone_ent) * TOT_W'(w_pulses);
        end
        if (r_state == fsk2a_pkg::S_CHECK) begin
            r_left <= w_pulses;
            if (w_too_long) begin
                r_status <= fsk2a_pkg::ST_LONG;
            end else begin
                r_hi <= fsk2a_pkg::OUT_W'(w_hi);
                r_lo <= fsk2a_pkg::OUT_W'(r_tone_ent - w_hi);
            end
        end
        if (w_out_take) begin
            r_left <= r_left - 1'b1;
        end
    end

    assign o_high_entries = r_hi;
    assign o_low_entries  = r_lo;
    assign o_tone_is_long = r_bit;
    assign o_last_of_bit  = w_final;
    assign o_status       = r_status;

endmodule

>>> hw/rtl/fsk2a_checker.sv
// Port-level checks for the FSK2a pulse modulator, bound to the top level.
module fsk2a_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [fsk2a_pkg::OUT_W-1:0]        o_high_entries,
    input logic [fsk2a_pkg::OUT_W-1:0]        o_low_entries,
    input logic                               o_tone_is_long,
    input logic                               o_last_of_bit,
    input logic [1:0]                         o_status
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != fsk2a_pkg::ST_OK
        |-> o_last_of_bit && o_high_entries == '0 && o_low_entries == '0)
        else $error("error result not a single empty result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tone_is_long)
            && $stable(o_status) && $stable(o_high_entries) && $stable(o_low_entries)
            && $stable(o_last_of_bit))
        else $error("stalled result changed");

endmodule

bind fsk2a_pulse_modulator fsk2a_checker u_checker (.*);

>>> verif/fsk2a_pulse_checker.sv
// Checker for the FSK2a pulse modulator: predicts tone pulse items and compares the results.
`timescale 1ns / 1ps
module fsk2a_pulse_checker #(
    parameter int TICKS_PER_CYCLE = fsk2a_pkg::TICKS_PER_CYCLE_DEF,
    parameter int MAX_ENTRIES     = fsk2a_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_FRAME_BITS  = fsk2a_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsk2a_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fsk2a_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                              i_bit_valid,
    input  logic                              i_bit_ready,
    input  logic                              i_data_bit,
    input  logic                              i_last_bit,
    input  logic                              i_pulse_valid,
    input  logic                              i_pulse_ready,
    input  logic [fsk2a_pkg::OUT_W-1:0]       i_high_entries,
    input  logic [fsk2a_pkg::OUT_W-1:0]       i_low_entries,
    input  logic                              i_tone_is_long,
    input  logic                              i_last_of_bit,
    input  logic [1:0]                        i_status,
    output int                                o_fail_count,
    output int                                o_pending
);
    import fsk2a_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] high_entries;
        logic [OUT_W-1:0] low_entries;
        logic             tone_is_long;
        logic             last_of_bit;
        t_status          status;
    } t_tone_pulse;

    t_cfg          settings;
    logic [31:0]   frame_entries;
    logic [31:0]   frame_bits;
    t_tone_pulse   pulse_q[$];
    int            mismatch_count = 0;

    task automatic report_failure(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        // drop bits above each register's width
        case (idx)
            CFG_TOP:       settings.top       = value[TOP_W-1:0];
            CFG_SHORT_CYC: settings.short_cyc = value[TONE_W-1:0];
            CFG_LONG_CYC:  settings.long_cyc  = value[TONE_W-1:0];
            CFG_MARK_CYC:  settings.mark_cyc  = value[TONE_W-1:0];
            CFG_SHORT_CNT: settings.short_cnt = value[CNT_W-1:0];
            CFG_LONG_CNT:  settings.long_cnt  = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_tone_pulses(input logic bit_in, input logic last_in);
        logic [31:0] top;
        logic [31:0] short_t;
        logic [31:0] long_t;
        logic [31:0] mark_t;
        logic [31:0] tone_ent;
        logic [31:0] pulses;
        logic [31:0] mark_e;
        logic [31:0] total;
        t_tone_pulse p;
        int k;
        top     = 32'(settings.top);
        short_t = 32'(settings.short_cyc) * TICKS_PER_CYCLE;
        long_t  = 32'(settings.long_cyc) * TICKS_PER_CYCLE;
        mark_t  = 32'(settings.mark_cyc) * TICKS_PER_CYCLE;
        p.high_entries = '0;
        p.low_entries  = '0;
        p.tone_is_long = bit_in;
        p.last_of_bit  = 1'b1;
        p.status       = ST_TIMING;
        if (top < MIN_TOP || short_t % top != 0 || long_t % top != 0 || mark_t % top != 0) begin
            pulse_q.push_back(p);
        end else begin
            tone_ent = (bit_in ? long_t : short_t) / top;
            pulses   = bit_in ? 32'(settings.long_cnt) : 32'(settings.short_cnt);
            mark_e   = mark_t / top;
            total    = tone_ent * pulses;
            if (frame_bits + 1 > MAX_FRAME_BITS || frame_entries + total > MAX_ENTRIES) begin
                p.status = ST_LONG;
                pulse_q.push_back(p);
            end else begin
                frame_bits    = frame_bits + 1;
                frame_entries = frame_entries + total;
                p.status       = ST_OK;
                p.high_entries = OUT_W'(mark_e < tone_ent ? mark_e : tone_ent);
                p.low_entries  = OUT_W'(tone_ent) - p.high_entries;
                // an empty tone still counts the bit but emits nothing
                if (tone_ent != 0) begin
                    for (k = 0; k < pulses; k++) begin
                        p.last_of_bit = (k == pulses - 1);
                        pulse_q.push_back(p);
                    end
                end
            end
        end
        if (last_in) begin
            frame_bits    = '0;
            frame_entries = '0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_tone_pulse want;
        if (!i_rst_n) begin
            settings.top       = TOP_RST;
            settings.short_cyc = SHORT_CYC_RST;
            settings.long_cyc  = LONG_CYC_RST;
            settings.mark_cyc  = MARK_CYC_RST;
            settings.short_cnt = SHORT_CNT_RST;
            settings.long_cnt  = LONG_CNT_RST;
            frame_entries      = '0;
            frame_bits         = '0;
            pulse_q.delete();
        end else begin
            if (i_cfg_we)
                apply_write(i_cfg_idx, i_cfg_wdata);
            // compare first, so a result cannot pair with an item taken at the same edge
            if (i_pulse_valid && i_pulse_ready) begin
                if (pulse_q.size() == 0) begin
                    report_failure($sformatf(
                        "unexpected pulse item: high %0d low %0d long %0b last %0b status %0d",
                        i_high_entries, i_low_entries, i_tone_is_long, i_last_of_bit, i_status));
                end else begin
                    want = pulse_q.pop_front();
                    if (i_high_entries !== want.high_entries ||
                        i_low_entries  !== want.low_entries  ||
                        i_tone_is_long !== want.tone_is_long ||
                        i_last_of_bit  !== want.last_of_bit  ||
                        i_status       !== want.status)
                        report_failure($sformatf(
                            "pulse item mismatch: got %0d/%0d/%0b/%0b/%0d want %0d/%0d/%0b/%0b/%0d",
                            i_high_entries, i_low_entries, i_tone_is_long, i_last_of_bit,
                            i_status, want.high_entries, want.low_entries, want.tone_is_long,
                            want.last_of_bit, want.status));
                end
            end
            if (i_bit_valid && i_bit_ready)
                predict_tone_pulses(i_data_bit, i_last_bit);
        end
        o_fail_count <= mismatch_count;
        o_pending    <= pulse_q.size();
    end

endmodule

>>> verif/fsk2a_pulse_modulator_tb.sv
// Testbench top for the FSK2a pulse modulator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module fsk2a_pulse_modulator_tb;
    import fsk2a_pkg::*;

    localparam int RANDOM_ITEMS   = 410;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  bit_valid   = 1'b0;
    logic                  data_bit    = 1'b0;
    logic                  last_bit    = 1'b0;
    logic                  bit_ready;
    logic                  pulse_valid;
    logic                  pulse_ready = 1'b0;
    logic [OUT_W-1:0]      high_entries;
    logic [OUT_W-1:0]      low_entries;
    logic                  tone_is_long;
    logic                  last_of_bit;
    logic [1:0]            status;
    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    bit                    gaps_off     = 1'b0;
    bit                    stalls_off   = 1'b0;

    fsk2a_pulse_modulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (bit_valid),
        .o_in_ready     (bit_ready),
        .i_data_bit     (data_bit),
        .i_last_bit     (last_bit),
        .o_out_valid    (pulse_valid),
        .i_out_ready    (pulse_ready),
        .o_high_entries (high_entries),
        .o_low_entries  (low_entries),
        .o_tone_is_long (tone_is_long),
        .o_last_of_bit  (last_of_bit),
        .o_status       (status)
    );

    fsk2a_pulse_checker pulse_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_bit_valid    (bit_valid),
        .i_bit_ready    (bit_ready),
        .i_data_bit     (data_bit),
        .i_last_bit     (last_bit),
        .i_pulse_valid  (pulse_valid),
        .i_pulse_ready  (pulse_ready),
        .i_high_entries (high_entries),
        .i_low_entries  (low_entries),
        .i_tone_is_long (tone_is_long),
        .i_last_of_bit  (last_of_bit),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short waits, now and then a long one
    function automatic int pick_wait();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cfg make_settings(input int top, input int short_cyc, input int long_cyc,
                                           input int mark_cyc, input int short_cnt,
                                           input int long_cnt);
        t_cfg s;
        s.top       = TOP_W'(top);
        s.short_cyc = TONE_W'(short_cyc);
        s.long_cyc  = TONE_W'(long_cyc);
        s.mark_cyc  = TONE_W'(mark_cyc);
        s.short_cnt = CNT_W'(short_cnt);
        s.long_cnt  = CNT_W'(long_cnt);
        return s;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        int unsigned top;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        int unsigned stride;
        int unsigned cap;
        if ($urandom_range(0, 7) == 0) begin
            // anything goes: mostly a timing error
            s.top       = $urandom_range(0, 1) ? TOP_W'($urandom) : TOP_W'($urandom_range(0, 24));
            s.short_cyc = TONE_W'($urandom);
            s.long_cyc  = TONE_W'($urandom);
            s.mark_cyc  = TONE_W'($urandom);
            s.short_cnt = CNT_W'($urandom);
            s.long_cnt  = CNT_W'($urandom);
        end else begin
            // keep every tick count a multiple of the counter top
            top = $urandom_range(3, 32);
            a = top;
            b = TICKS_PER_CYCLE_DEF;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            stride = top / a;
            cap = ($urandom_range(0, 3) == 0) ? 255 : 32;
            s.top       = TOP_W'(top);
            s.short_cyc = TONE_W'(stride * $urandom_range(0, cap / stride));
            s.long_cyc  = TONE_W'(stride * $urandom_range(0, cap / stride));
            s.mark_cyc  = TONE_W'(stride * $urandom_range(0, 255 / stride));
            s.short_cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom)
                                                       : CNT_W'($urandom_range(1, 6));
            s.long_cnt  = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom)
                                                       : CNT_W'($urandom_range(1, 6));
        end
        return s;
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // junk in the upper bits must be ignored
    task automatic load_settings(input t_cfg s);
        if ($urandom_range(0, 1) == 0)
            put_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        put_reg(CFG_TOP, s.top);
        put_reg(CFG_SHORT_CYC, {8'($urandom), s.short_cyc});
        put_reg(CFG_LONG_CYC, {8'($urandom), s.long_cyc});
        put_reg(CFG_MARK_CYC, {8'($urandom), s.mark_cyc});
        put_reg(CFG_SHORT_CNT, {10'($urandom), s.short_cnt});
        put_reg(CFG_LONG_CNT, {10'($urandom), s.long_cnt});
        cfg_we <= 1'b0;
    endtask

    task automatic send_bit(input logic b, input logic l);
        bit_valid <= 1'b1;
        data_bit  <= b;
        last_bit  <= l;
        do @(posedge i_clk); while (!bit_ready);
        if (!gaps_off && $urandom_range(0, 2) == 0) begin
            bit_valid <= 1'b0;
            repeat (pick_wait()) @(posedge i_clk);
        end
    endtask

    // hold the sender until every pulse item is out, then let the block settle
    task automatic wait_for_idle();
        bit_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (!stalls_off && $urandom_range(0, 5) == 0) begin
                pulse_ready <= 1'b0;
                repeat (pick_wait()) @(posedge i_clk);
            end
            pulse_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (bit_valid && bit_ready) || (pulse_valid && pulse_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("fsk2a_pulse_modulator regression: fail");
            $finish;
        end
    end

    initial begin
        int sent;
        int phase;
        int n;
        int k;
        int frame_left;
        logic lb;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings as after reset
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        // mark longer than either tone, most pulses per bit
        wait_for_idle();
        load_settings(make_settings(8, 2, 3, 255, 63, 63));
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        // counter top below the minimum
        wait_for_idle();
        load_settings(make_settings(0, 8, 10, 5, 6, 5));
        send_bit(1'b1, 1'b1);
        wait_for_idle();
        load_settings(make_settings(2, 8, 10, 5, 6, 5));
        send_bit(1'b0, 1'b0);
        // widest counter top with silent tones: empty bits
        wait_for_idle();
        load_settings(make_settings(65535, 0, 0, 0, 63, 63));
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        // short tone, then mark, not a multiple of the counter top
        wait_for_idle();
        load_settings(make_settings(16, 1, 2, 2, 6, 5));
        send_bit(1'b0, 1'b1);
        wait_for_idle();
        load_settings(make_settings(16, 2, 4, 3, 6, 5));
        send_bit(1'b1, 1'b0);
        // entry limit: one oversized bit, then a frame that crosses it
        wait_for_idle();
        load_settings(make_settings(8, 16, 255, 0, 63, 63));
        send_bit(1'b1, 1'b0);
        repeat (4) send_bit(1'b0, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b0, 1'b1);
        send_bit(1'b0, 1'b1);
        // no pulses for a zero bit
        wait_for_idle();
        load_settings(make_settings(4, 1, 1, 1, 0, 1));
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);

        sent = 0;
        phase = 0;
        frame_left = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_for_idle();
            gaps_off   = (phase % 4 == 1);
            stalls_off = (phase % 4 == 1);
            if (phase == 2) begin
                // one pulse per zero bit, run the frame past the bit limit
                load_settings(make_settings(8, 1, 1, 1, 1, 0));
                n = MAX_FRAME_BITS_DEF + 2;
            end else begin
                load_settings(random_settings());
                n = $urandom_range(15, 40);
            end
            for (k = 0; k < n; k++) begin
                if (phase == 2) begin
                    lb = (k == n - 1);
                end else begin
                    if (frame_left == 0)
                        frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                                  : $urandom_range(1, 10);
                    lb = (frame_left == 1) ^ ($urandom_range(0, 15) == 0);
                    frame_left = lb ? 0 : frame_left - 1;
                end
                send_bit($urandom_range(0, 1), lb);
                if (phase != 2 && $urandom_range(0, 49) == 0)
                    wait_for_idle();
            end
            sent += n;
            phase++;
        end

        wait_for_idle();
        if (fail_count == 0)
            $display("fsk2a_pulse_modulator regression: pass");
        else
            $display("fsk2a_pulse_modulator regression: fail");
        $finish;
    end

endmodule
